### rtl/ray_box_slab_intersect_macros.svh
// ----------------------------------------------------------------------------
// Ray/box slab intersect - assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

// same-cycle implication, masked during reset
`define RBSI_CHK_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define RBSI_CHK_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

// next-cycle implication, also checked in reset
`define RBSI_CHK_NXT_RST(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) (ant) |=> (con)) \
        else $error(msg);

`endif

### rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants and types of the ray/box slab intersect block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

    localparam int THR_W = 16;
    localparam logic [THR_W-1:0] THR_RST = 16'd1;

    typedef struct packed {
        logic par;
        logic rej;
    } t_axis_flag;

endpackage

`default_nettype wire

### rtl/rbsi_prep.sv
// ----------------------------------------------------------------------------
// rbsi_prep
// One axis: slab distances, magnitudes, parallel test and origin check.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_prep
    import rbsi_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  wire  [COORD_WIDTH-1:0] i_o,
    input  wire  [COORD_WIDTH-1:0] i_d,
    input  wire  [COORD_WIDTH-1:0] i_bmin,
    input  wire  [COORD_WIDTH-1:0] i_bmax,
    input  wire  [THR_W-1:0]       i_thr,
    output logic [COORD_WIDTH-1:0] o_org,
    output logic [COORD_WIDTH-1:0] o_nm_lo,
    output logic                   o_nn_lo,
    output logic [COORD_WIDTH-1:0] o_nm_hi,
    output logic                   o_nn_hi,
    output logic [COORD_WIDTH-1:0] o_dm,
    output logic                   o_dn,
    output logic                   o_dz,
    output t_axis_flag             o_flag
);

    localparam int CW = COORD_WIDTH;

    logic [CW:0]   w_nlo;
    logic [CW:0]   w_nhi;
    logic [CW:0]   w_nlo_m;
    logic [CW:0]   w_nhi_m;
    logic [CW-1:0] w_dm;
    logic          w_dz;
    logic          w_par;
    logic          w_out;

    assign w_nlo   = {i_bmin[CW-1], i_bmin} - {i_o[CW-1], i_o};
    assign w_nhi   = {i_bmax[CW-1], i_bmax} - {i_o[CW-1], i_o};
    assign w_nlo_m = w_nlo[CW] ? (~w_nlo + 1'b1) : w_nlo;
    assign w_nhi_m = w_nhi[CW] ? (~w_nhi + 1'b1) : w_nhi;
    assign w_dm    = i_d[CW-1] ? (~i_d + 1'b1) : i_d;
    assign w_dz    = (i_d == '0);
    assign w_par   = w_dz || (w_dm < {{(CW-THR_W){1'b0}}, i_thr});
    assign w_out   = ($signed(i_o) < $signed(i_bmin)) || ($signed(i_o) > $signed(i_bmax));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_org      <= i_o;
            o_nm_lo    <= w_nlo_m[CW-1:0];
            o_nn_lo    <= w_nlo[CW];
            o_nm_hi    <= w_nhi_m[CW-1:0];
            o_nn_hi    <= w_nhi[CW];
            o_dm       <= w_dm;
            o_dn       <= i_d[CW-1];
            o_dz       <= w_dz;
            o_flag.par <= w_par;
            o_flag.rej <= w_par && w_out;
        end
    end

endmodule

`default_nettype wire

### rtl/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider, (n << FRAC_BITS) / d, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  wire  [COORD_WIDTH-1:0] i_n,
    input  wire  [COORD_WIDTH-1:0] i_d,
    output logic [COORD_WIDTH-1:0] o_q,
    output logic                   o_ovf
);

    localparam int CW = COORD_WIDTH;
    localparam int SH = COORD_WIDTH - FRAC_BITS;

    logic [CW-1:0] r_rem [0:CW-1];
    logic [CW-1:0] r_nb  [0:CW-1];
    logic [CW-1:0] r_d   [0:CW-1];
    logic [CW-1:0] r_q   [0:CW];
    logic          r_ovf [0:CW];

    logic [CW:0]   w_r   [1:CW];
    logic [CW:0]   w_s   [1:CW];
    logic          w_ge  [1:CW];
    logic [CW-1:0] w_top;
    logic [CW-1:0] w_nb0;

    assign w_top = i_n >> SH;
    assign w_nb0 = i_n << FRAC_BITS;

    always_comb begin
        for (int k = 1; k <= CW; k++) begin
            w_r[k]  = {r_rem[k-1], r_nb[k-1][CW-1]};
            w_ge[k] = (w_r[k] >= {1'b0, r_d[k-1]});
            w_s[k]  = w_ge[k] ? (w_r[k] - {1'b0, r_d[k-1]}) : w_r[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_top;
            r_nb[0]  <= w_nb0;
            r_d[0]   <= i_d;
            r_q[0]   <= '0;
            r_ovf[0] <= (w_top >= i_d);
            for (int k = 1; k < CW; k++) begin
                r_rem[k] <= w_s[k][CW-1:0];
                r_nb[k]  <= r_nb[k-1] << 1;
                r_d[k]   <= r_d[k-1];
            end
            for (int k = 1; k <= CW; k++) begin
                r_q[k]   <= {r_q[k-1][CW-2:0], w_ge[k]};
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_q   = r_q[CW];
    assign o_ovf = r_ovf[CW];

endmodule

`default_nettype wire

### rtl/rbsi_point.sv
// ----------------------------------------------------------------------------
// rbsi_point
// Ray point on one axis: origin +/- (|d| * t) >> FRAC_BITS, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_point #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  wire  [COORD_WIDTH-1:0] i_o,
    input  wire  [COORD_WIDTH-1:0] i_dm,
    input  wire                    i_dn,
    input  wire  [COORD_WIDTH-2:0] i_t,
    input  wire                    i_keep,
    output logic [COORD_WIDTH-1:0] o_p
);

    localparam int CW = COORD_WIDTH;
    localparam logic [2*CW-2:0] PCAP = {{(CW-2){1'b0}}, 1'b1, {CW{1'b0}}};

    logic [2*CW-2:0] r_prod;
    logic [CW-1:0]   r_o;
    logic            r_dn;
    logic            r_keep;

    logic [2*CW-2:0] w_sh;
    logic [CW:0]     w_m;
    logic [CW+1:0]   w_v;
    logic [CW-1:0]   w_p;

    assign w_sh = r_prod >> FRAC_BITS;
    assign w_m  = (w_sh > PCAP) ? PCAP[CW:0] : w_sh[CW:0];
    assign w_v  = r_dn ? ({{2{r_o[CW-1]}}, r_o} - {1'b0, w_m})
                       : ({{2{r_o[CW-1]}}, r_o} + {1'b0, w_m});

    always_comb begin
        if (w_v[CW+1:CW-1] == 3'b000 || w_v[CW+1:CW-1] == 3'b111) begin
            w_p = w_v[CW-1:0];
        end else if (w_v[CW+1]) begin
            w_p = {1'b1, {(CW-1){1'b0}}};
        end else begin
            w_p = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_dm * i_t;
            r_o    <= i_o;
            r_dn   <= i_dn;
            r_keep <= i_keep;
            o_p    <= r_keep ? w_p : '0;
        end
    end

endmodule

`default_nettype wire

### rtl/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect - ray against axis-aligned box, slab method
// Most of the pipeline is the dividers, which resolve one quotient bit per stage.
// Throughput one item per cycle; a stall at the output freezes the whole pipe.
// Reset clears all valid bits and sets the parallel threshold to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersect
    import rbsi_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire  [COORD_WIDTH-1:0] i_origin_x,
    input  wire  [COORD_WIDTH-1:0] i_origin_y,
    input  wire  [COORD_WIDTH-1:0] i_origin_z,
    input  wire  [COORD_WIDTH-1:0] i_dir_x,
    input  wire  [COORD_WIDTH-1:0] i_dir_y,
    input  wire  [COORD_WIDTH-1:0] i_dir_z,
    input  wire  [COORD_WIDTH-1:0] i_box_min_x,
    input  wire  [COORD_WIDTH-1:0] i_box_min_y,
    input  wire  [COORD_WIDTH-1:0] i_box_min_z,
    input  wire  [COORD_WIDTH-1:0] i_box_max_x,
    input  wire  [COORD_WIDTH-1:0] i_box_max_y,
    input  wire  [COORD_WIDTH-1:0] i_box_max_z,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [THR_W-1:0]       i_cfg_data,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic                   o_hit,
    output logic [COORD_WIDTH-2:0] o_t_enter,
    output logic [COORD_WIDTH-2:0] o_t_exit,
    output logic [COORD_WIDTH-1:0] o_enter_x,
    output logic [COORD_WIDTH-1:0] o_enter_y,
    output logic [COORD_WIDTH-1:0] o_enter_z,
    output logic [COORD_WIDTH-1:0] o_leave_x,
    output logic [COORD_WIDTH-1:0] o_leave_y,
    output logic [COORD_WIDTH-1:0] o_leave_z
);

    localparam int CW  = COORD_WIDTH;
    localparam int DL  = COORD_WIDTH + 1;
    localparam int NST = DL + 5;
    localparam logic [CW-1:0]     TCAP = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW:0] TMAX = {2'b00, {(CW-1){1'b1}}};

    typedef struct packed {
        logic [2:0][CW-1:0] org;
        logic [2:0][CW-1:0] dm;
        logic [2:0]         dn;
        logic [2:0]         nn_lo;
        logic [2:0]         nn_hi;
        logic [2:0]         par;
        logic               ok;
    } t_side;

    logic [THR_W-1:0] r_thr;
    logic [NST-1:0]   r_vld;
    logic             w_adv;

    logic [CW-1:0] w_in_o  [3];
    logic [CW-1:0] w_in_d  [3];
    logic [CW-1:0] w_in_lo [3];
    logic [CW-1:0] w_in_hi [3];

    logic [CW-1:0] w_org   [3];
    logic [CW-1:0] w_nm_lo [3];
    logic          w_nn_lo [3];
    logic [CW-1:0] w_nm_hi [3];
    logic          w_nn_hi [3];
    logic [CW-1:0] w_dm    [3];
    logic          w_dn    [3];
    logic          w_dz    [3];
    t_axis_flag    w_flag  [3];

    logic [CW-1:0] w_q_lo   [3];
    logic          w_ovf_lo [3];
    logic [CW-1:0] w_q_hi   [3];
    logic          w_ovf_hi [3];

    t_side n_side;
    t_side r_side [0:DL-1];

    // interval stage
    logic signed [CW:0] n_near [3];
    logic signed [CW:0] n_far  [3];
    logic signed [CW:0] r_near [3];
    logic signed [CW:0] r_far  [3];
    t_side              r_s1;

    // combine stage
    logic signed [CW:0] n_lo;
    logic signed [CW:0] n_hi;
    logic [CW-2:0]      r_lo2;
    logic [CW-2:0]      r_hi2;
    logic               r_hit2;
    t_side              r_s2;

    logic [CW-2:0] r_lo3;
    logic [CW-2:0] r_hi3;
    logic          r_hit3;

    logic [CW-1:0] w_pe [3];
    logic [CW-1:0] w_pl [3];

    assign w_adv       = !(r_vld[NST-1] && i_stall);
    assign o_stall     = !w_adv;
    assign o_valid     = r_vld[NST-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    assign w_in_o[0]  = i_origin_x;
    assign w_in_o[1]  = i_origin_y;
    assign w_in_o[2]  = i_origin_z;
    assign w_in_d[0]  = i_dir_x;
    assign w_in_d[1]  = i_dir_y;
    assign w_in_d[2]  = i_dir_z;
    assign w_in_lo[0] = i_box_min_x;
    assign w_in_lo[1] = i_box_min_y;
    assign w_in_lo[2] = i_box_min_z;
    assign w_in_hi[0] = i_box_max_x;
    assign w_in_hi[1] = i_box_max_y;
    assign w_in_hi[2] = i_box_max_z;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbsi_prep #(.COORD_WIDTH(CW)) u_prep (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_o     (w_in_o[a]),
            .i_d     (w_in_d[a]),
            .i_bmin  (w_in_lo[a]),
            .i_bmax  (w_in_hi[a]),
            .i_thr   (r_thr),
            .o_org   (w_org[a]),
            .o_nm_lo (w_nm_lo[a]),
            .o_nn_lo (w_nn_lo[a]),
            .o_nm_hi (w_nm_hi[a]),
            .o_nn_hi (w_nn_hi[a]),
            .o_dm    (w_dm[a]),
            .o_dn    (w_dn[a]),
            .o_dz    (w_dz[a]),
            .o_flag  (w_flag[a])
        );

        rbsi_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_lo (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_n   (w_nm_lo[a]),
            .i_d   (w_dm[a]),
            .o_q   (w_q_lo[a]),
            .o_ovf (w_ovf_lo[a])
        );

        rbsi_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div_hi (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_n   (w_nm_hi[a]),
            .i_d   (w_dm[a]),
            .o_q   (w_q_hi[a]),
            .o_ovf (w_ovf_hi[a])
        );

        rbsi_point #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_pt_enter (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_o    (r_s2.org[a]),
            .i_dm   (r_s2.dm[a]),
            .i_dn   (r_s2.dn[a]),
            .i_t    (r_lo2),
            .i_keep (r_hit2),
            .o_p    (w_pe[a])
        );

        rbsi_point #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_pt_leave (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_o    (r_s2.org[a]),
            .i_dm   (r_s2.dm[a]),
            .i_dn   (r_s2.dn[a]),
            .i_t    (r_hi2),
            .i_keep (r_hit2),
            .o_p    (w_pl[a])
        );
    end

    // side data travels beside the dividers
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_side.org[a]   = w_org[a];
            n_side.dm[a]    = w_dm[a];
            n_side.dn[a]    = w_dn[a];
            n_side.nn_lo[a] = w_nn_lo[a];
            n_side.nn_hi[a] = w_nn_hi[a];
            n_side.par[a]   = w_flag[a].par;
        end
        n_side.ok = !(w_dz[0] && w_dz[1] && w_dz[2])
                 && !(w_flag[0].rej || w_flag[1].rej || w_flag[2].rej);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= n_side;
            for (int k = 1; k < DL; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // signed, capped slab parameters; near/far per axis
    always_comb begin
        logic [CW-1:0]      v_m1;
        logic [CW-1:0]      v_m2;
        logic signed [CW:0] v_t1;
        logic signed [CW:0] v_t2;
        for (int a = 0; a < 3; a++) begin
            v_m1 = (w_ovf_lo[a] || w_q_lo[a] > TCAP) ? TCAP : w_q_lo[a];
            v_m2 = (w_ovf_hi[a] || w_q_hi[a] > TCAP) ? TCAP : w_q_hi[a];
            v_t1 = (r_side[DL-1].nn_lo[a] ^ r_side[DL-1].dn[a])
                 ? -$signed({1'b0, v_m1}) : $signed({1'b0, v_m1});
            v_t2 = (r_side[DL-1].nn_hi[a] ^ r_side[DL-1].dn[a])
                 ? -$signed({1'b0, v_m2}) : $signed({1'b0, v_m2});
            if (r_side[DL-1].par[a]) begin
                n_near[a] = '0;
                n_far[a]  = TMAX;
            end else if (v_t1 < v_t2) begin
                n_near[a] = v_t1;
                n_far[a]  = v_t2;
            end else begin
                n_near[a] = v_t2;
                n_far[a]  = v_t1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                r_near[a] <= n_near[a];
                r_far[a]  <= n_far[a];
            end
            r_s1 <= r_side[DL-1];
        end
    end

    always_comb begin
        n_lo = '0;
        n_hi = TMAX;
        for (int a = 0; a < 3; a++) begin
            if (r_near[a] > n_lo) begin
                n_lo = r_near[a];
            end
            if (r_far[a] < n_hi) begin
                n_hi = r_far[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lo2  <= n_lo[CW-2:0];
            r_hi2  <= n_hi[CW-2:0];
            r_hit2 <= r_s1.ok && !(n_lo > n_hi);
            r_s2   <= r_s1;
            r_lo3  <= r_lo2;
            r_hi3  <= r_hi2;
            r_hit3 <= r_hit2;
            o_hit     <= r_hit3;
            o_t_enter <= r_hit3 ? r_lo3 : '0;
            o_t_exit  <= r_hit3 ? r_hi3 : '0;
        end
    end

    assign o_enter_x = w_pe[0];
    assign o_enter_y = w_pe[1];
    assign o_enter_z = w_pe[2];
    assign o_leave_x = w_pl[0];
    assign o_leave_y = w_pl[1];
    assign o_leave_z = w_pl[2];

endmodule

`default_nettype wire

### rtl/rbsi_chk.sv
// ----------------------------------------------------------------------------
// rbsi_chk
// Port-level checks of the ray/box slab intersect block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_box_slab_intersect_macros.svh"

module rbsi_chk #(
    parameter int COORD_WIDTH = 32
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   o_valid,
    input wire                   i_stall,
    input wire                   o_hit,
    input wire [COORD_WIDTH-2:0] o_t_enter,
    input wire [COORD_WIDTH-2:0] o_t_exit
);

    `RBSI_CHK_NXT_RST(a_rst_empty, !i_rst_n, !o_valid, "item out of reset")
    `RBSI_CHK_NXT(a_hold, o_valid && i_stall, o_valid, "stalled item dropped")
    `RBSI_CHK_IMP(a_miss_zero, o_valid && !o_hit, o_t_enter == '0 && o_t_exit == '0, "miss not zeroed")
    `RBSI_CHK_IMP(a_order, o_valid && o_hit, o_t_enter <= o_t_exit, "hit with enter past exit")

endmodule

bind ray_box_slab_intersect rbsi_chk #(.COORD_WIDTH(COORD_WIDTH)) u_rbsi_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_hit     (o_hit),
    .o_t_enter (o_t_enter),
    .o_t_exit  (o_t_exit)
);

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb - ray/box slab intersect testbench
// Drives ray/box items with bursty valid and a random output stall, predicts
// each result with a slab-method model of its own and compares every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rbsi_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int LAT = CW + 6;
    localparam longint TMAX = (64'd1 << (CW - 1)) - 1;
    localparam longint TCAP = 64'd1 << (CW - 1);
    localparam longint PCAP = 64'd1 << CW;
    localparam int N_RAND = 1630;
    localparam longint CYC_LIMIT = 400000;

    typedef struct packed {
        logic [CW-1:0] ox, oy, oz, dx, dy, dz, nx, ny, nz, xx, xy, xz;
    } ray_box_t;

    typedef struct packed {
        logic          hit;
        logic [CW-2:0] t_in, t_out;
        logic [CW-1:0] ex, ey, ez, lx, ly, lz;
    } hit_rec_t;

    typedef struct {
        ray_box_t      rb;
        bit            fixed;
        hit_rec_t      res;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [THR_W-1:0] i_cfg_data = '0;
    ray_box_t drv = '0;
    logic o_stall, o_cfg_ready, o_valid, o_hit;
    logic [CW-2:0] o_t_enter, o_t_exit;
    logic [CW-1:0] o_enter_x, o_enter_y, o_enter_z, o_leave_x, o_leave_y, o_leave_z;

    always #6 i_clk = ~i_clk;

    ray_box_slab_intersect dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_origin_x(drv.ox), .i_origin_y(drv.oy), .i_origin_z(drv.oz),
        .i_dir_x(drv.dx), .i_dir_y(drv.dy), .i_dir_z(drv.dz),
        .i_box_min_x(drv.nx), .i_box_min_y(drv.ny), .i_box_min_z(drv.nz),
        .i_box_max_x(drv.xx), .i_box_max_y(drv.xy), .i_box_max_z(drv.xz),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit),
        .o_t_enter(o_t_enter), .o_t_exit(o_t_exit),
        .o_enter_x(o_enter_x), .o_enter_y(o_enter_y), .o_enter_z(o_enter_z),
        .o_leave_x(o_leave_x), .o_leave_y(o_leave_y), .o_leave_z(o_leave_z)
    );

    logic [15:0] thr_model;
    hit_rec_t    pending_hits[$];
    int          n_err = 0;
    int          n_got = 0;
    int          n_hits = 0;
    longint      cyc = 0;
    int          hold_off = 0;
    bit          stall_mode = 1'b0;

    function automatic longint sx(logic [CW-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint absv(longint v);
        return v < 0 ? -v : v;
    endfunction

    // (n << FB) / d truncated, capped at TCAP
    function automatic longint slab_div(longint n, longint d);
        longint q;
        longint r;
        q = n / d;
        r = n % d;
        if (q > (TCAP >> FB)) return TCAP;
        for (int i = 0; i < FB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r -= d;
                q |= 1;
            end
        end
        return q > TCAP ? TCAP : q;
    endfunction

    function automatic logic [CW-1:0] point_at(longint o, longint d, longint t);
        logic [127:0] p;
        logic [127:0] s;
        longint m;
        longint v;
        p = 128'(absv(d)) * 128'(t);
        s = p >> FB;
        m = (s > 128'(PCAP)) ? PCAP : longint'(s[63:0]);
        v = d < 0 ? o - m : o + m;
        if (v > TMAX) v = TMAX;
        if (v < -TCAP) v = -TCAP;
        return v[CW-1:0];
    endfunction

    function automatic hit_rec_t slab_test(ray_box_t rb, logic [15:0] thr);
        hit_rec_t r;
        longint o[3], d[3], bl[3], bh[3];
        longint lo, hi, ad, t1, t2, num;
        bit ok;
        r = '0;
        o  = '{sx(rb.ox), sx(rb.oy), sx(rb.oz)};
        d  = '{sx(rb.dx), sx(rb.dy), sx(rb.dz)};
        bl = '{sx(rb.nx), sx(rb.ny), sx(rb.nz)};
        bh = '{sx(rb.xx), sx(rb.xy), sx(rb.xz)};
        lo = 0;
        hi = TMAX;
        ok = !(d[0] == 0 && d[1] == 0 && d[2] == 0);
        for (int k = 0; k < 3; k++) begin
            ad = absv(d[k]);
            if (ad == 0 || ad < longint'(thr)) begin
                if (o[k] < bl[k] || o[k] > bh[k]) ok = 0;
            end else begin
                num = bl[k] - o[k];
                t1 = slab_div(absv(num), ad);
                if ((num < 0) != (d[k] < 0)) t1 = -t1;
                num = bh[k] - o[k];
                t2 = slab_div(absv(num), ad);
                if ((num < 0) != (d[k] < 0)) t2 = -t2;
                if (t2 < t1) begin
                    num = t1;
                    t1 = t2;
                    t2 = num;
                end
                if (t1 > lo) lo = t1;
                if (t2 < hi) hi = t2;
            end
        end
        if (lo > hi) ok = 0;
        if (ok) begin
            r.hit = 1'b1;
            r.t_in = lo[CW-2:0];
            r.t_out = hi[CW-2:0];
            r.ex = point_at(o[0], d[0], lo);
            r.ey = point_at(o[1], d[1], lo);
            r.ez = point_at(o[2], d[2], lo);
            r.lx = point_at(o[0], d[0], hi);
            r.ly = point_at(o[1], d[1], hi);
            r.lz = point_at(o[2], d[2], hi);
        end
        return r;
    endfunction

    // output side: sample at posedge, stall pattern of its own
    always @(posedge i_clk) begin
        hit_rec_t want;
        hit_rec_t got;
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_hit, o_t_enter, o_t_exit, o_enter_x, o_enter_y, o_enter_z,
                    o_leave_x, o_leave_y, o_leave_z};
            n_got++;
            if (pending_hits.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_hits.pop_front();
                if (got.hit) n_hits++;
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp %h got %h", want, got);
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < 3) begin
            stall_mode <= ~stall_mode;
            i_stall <= 1'b0;
        end else begin
            i_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
        end
    end

    function automatic logic [CW-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return CW'(signed'($urandom_range(0, 40 << FB)) - (20 << FB));
            2: return {1'b1, {(CW-1){1'b0}}};
            3: return {1'b0, {(CW-1){1'b1}}};
            default: return CW'(signed'($urandom_range(0, 8000)) - 4000) << 10;
        endcase
    endfunction

    function automatic logic [CW-1:0] rnd_dir();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CW'(signed'($urandom_range(0, 6)) - 3);
            2: return $urandom();
            3: return {1'b1, {(CW-1){1'b0}}};
            default: return CW'(signed'($urandom_range(0, 8 << FB)) - (4 << FB));
        endcase
    endfunction

    // mostly rays aimed at a small box so that hits are common
    function automatic ray_box_t rnd_ray();
        ray_box_t rb;
        logic [CW-1:0] c, h;
        rb = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_dir(), rnd_dir(), rnd_dir(),
               rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
        if ($urandom_range(0, 3) != 0) begin
            c = CW'(signed'($urandom_range(0, 20 << FB)) - (10 << FB));
            h = CW'($urandom_range(1, 4 << FB));
            rb.nx = c - h; rb.xx = c + h;
            rb.ny = c - h - 5; rb.xy = c + h;
            rb.nz = c - h; rb.xz = c + h + 7;
            rb.ox = CW'(signed'($urandom_range(0, 60 << FB)) - (30 << FB));
            rb.oy = CW'(signed'($urandom_range(0, 60 << FB)) - (30 << FB));
            rb.oz = CW'(signed'($urandom_range(0, 60 << FB)) - (30 << FB));
            rb.dx = c - rb.ox + CW'($urandom_range(0, 3000));
            rb.dy = c - rb.oy - CW'($urandom_range(0, 3000));
            rb.dz = c - rb.oz;
        end
        return rb;
    endfunction

    task automatic send_ray(ray_box_t rb);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6)) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        drv <= rb;
        i_valid <= 1'b1;
        pending_hits.push_back(slab_test(rb, thr_model));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_thr(logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        thr_model = v;
    endtask

    localparam logic [CW-1:0] ONE = 32'h0001_0000;
    localparam logic [CW-1:0] MAXP = 32'h7fff_ffff;
    localparam logic [CW-1:0] MINN = 32'h8000_0000;

    stim_row_t rows[$];
    hit_rec_t miss = '0;

    initial begin
        // origin, dir, box min, box max; fixed rows carry the typed result
        rows.push_back('{'{0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE}, 1, miss});
        rows.push_back('{'{-2*ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE}, 1,
                       '{1, ONE, 3*ONE, -ONE, 0, 0, ONE, 0, 0}});
        rows.push_back('{'{-2*ONE, 5*ONE, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE},
                       1, miss});
        rows.push_back('{'{0, 0, 0, ONE, 0, 0, ONE, -ONE, -ONE, ONE, ONE, ONE}, 1,
                       '{1, ONE, ONE, ONE, 0, 0, ONE, 0, 0}});
        rows.push_back('{'{-2*ONE, 0, 0, ONE, 0, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE}, 0,
                       miss});
        rows.push_back('{'{0, 0, 0, ONE, 0, 0, ONE, ONE, -ONE, 2*ONE, -ONE, ONE}, 1, miss});
        rows.push_back('{'{2*ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE}, 1,
                       miss});
        rows.push_back('{'{MINN, MINN, MINN, 1, 1, 1, MINN, MINN, MINN, MAXP, MAXP, MAXP},
                       0, miss});
        rows.push_back('{'{MAXP, MAXP, MAXP, MINN, MINN, MINN, MINN, MINN, MINN, MAXP,
                           MAXP, MAXP}, 0, miss});
        rows.push_back('{'{0, 0, 0, MAXP, 1, MINN, MINN, MINN, MINN, MAXP, MAXP, MAXP},
                       0, miss});
        rows.push_back('{'{0, 0, 0, -1, 0, 0, MINN, -ONE, -ONE, MAXP, ONE, ONE}, 0, miss});
        rows.push_back('{'{MINN, 0, 0, 1, 0, 0, MAXP, -ONE, -ONE, MAXP, ONE, ONE}, 0, miss});
        rows.push_back('{'{'1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1}, 0, miss});
        rows.push_back('{'{3*ONE, 0, 0, -ONE, 1, -1, -ONE, MINN, MINN, ONE, MAXP, MAXP},
                       0, miss});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        thr_model = 16'd1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_ray(rows[i].rb);
            if (rows[i].fixed && pending_hits[$] !== rows[i].res) begin
                n_err++;
                if (n_err <= 10)
                    $display("row %0d: table %h model %h", i, rows[i].res, pending_hits[$]);
            end
        end
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_thr(16'd0);
                1: write_thr(16'hffff);
                2: write_thr(16'd1);
                3: write_thr(16'h0400);
                default: write_thr(16'($urandom_range(0, 65535)));
            endcase
            // long receiver hold-off while items keep coming
            if (ph == 2) hold_off <= 300;
            for (int n = 0; n < N_RAND / 5; n++) begin
                send_ray(rnd_ray());
            end
            drain();
        end

        $display("tb: %0d rays checked, %0d hits, thresholds 0 to 65535, output held off",
                 n_got, n_hits);
        if (n_err == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("%0d mismatches", n_err);
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/rbsi_pkg.sv
rtl/rbsi_prep.sv
rtl/rbsi_div.sv
rtl/rbsi_point.sv
rtl/ray_box_slab_intersect.sv
rtl/rbsi_chk.sv
verif/tb.sv
